>>> rtl/gtfr_pkg.sv
// Shared types, widths and the gamma table for the fade ramp block.
// No dependencies; every other file imports this package.
package gtfr_pkg;

  localparam int CH_W      = 3;   // channel field
  localparam int TGT_W     = 12;  // requested target field
  localparam int LVL_W     = 8;   // stored / emitted level
  localparam int CNT_W     = 4;   // channel_count register
  localparam int TAB_AW    = 6;   // address width of the full gamma table
  localparam int TAB_ROOM  = 64;
  localparam int IN_DATA_W  = 16; // channel + target, padded to bytes
  localparam int OUT_DATA_W = 16; // channel + level, padded to bytes

  localparam logic [LVL_W-1:0] LEVEL_MAX   = 8'd255;
  localparam logic [CNT_W-1:0] CNT_RESET   = 4'd8;
  localparam int               CH_SLOTS    = 8;   // channels the field can name

  typedef logic [LVL_W-1:0] level_t;

  // Gamma table; positions past the listed 32 entries read as full scale
  localparam level_t GAMMA_TAB [TAB_ROOM] = '{
    8'd0,   8'd1,   8'd2,   8'd3,   8'd5,   8'd8,   8'd12,  8'd16,
    8'd21,  8'd26,  8'd32,  8'd38,  8'd45,  8'd52,  8'd60,  8'd68,
    8'd76,  8'd85,  8'd95,  8'd105, 8'd115, 8'd125, 8'd136, 8'd148,
    8'd160, 8'd172, 8'd185, 8'd198, 8'd211, 8'd225, 8'd239, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
  };

  function automatic level_t gamma_entry(input logic [TAB_AW-1:0] idx);
    return GAMMA_TAB[idx];
  endfunction

  // Write request from the sequencer into the per-channel level store
  typedef struct packed {
    logic             en;
    logic [CH_W-1:0]  ch;
    level_t           level;
  } lvl_wr_t;

  // Result of one pass through the shared table/compare unit
  typedef struct packed {
    level_t entry;  // table entry at the current index
    logic   gt;     // entry is above the operand
  } step_res_t;

endpackage

>>> rtl/gtfr_step_unit.sv
// Shared table lookup and magnitude compare used by every search and ramp step.
// Depends on gtfr_pkg for the gamma table and result struct.
module gtfr_step_unit import gtfr_pkg::*; #(
  parameter int IDX_W = 5
) (
  input  logic [IDX_W-1:0] idx,
  input  level_t           operand,
  output step_res_t        res
);

  level_t entry;

  // index zero-extended into the full table
  assign entry     = gamma_entry(TAB_AW'(idx));
  assign res.entry = entry;
  assign res.gt    = (entry > operand);

endmodule

>>> rtl/gtfr_level_store.sv
// Per-channel stored brightness, one register per channel, reset to zero.
// Depends on gtfr_pkg for the level type and write request struct.
module gtfr_level_store import gtfr_pkg::*; #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic            clk,
  input  logic            rst_n,
  input  lvl_wr_t         wr,
  input  logic [CH_W-1:0] rd_ch,
  output level_t          rd_level
);

  level_t lvl_r [DEPTH];

  // update on the final ramp step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) lvl_r[i] <= '0;
    end else if (wr.en) begin
      lvl_r[wr.ch[AW-1:0]] <= wr.level;
    end
  end

  assign rd_level = lvl_r[rd_ch[AW-1:0]];

endmodule

>>> rtl/gamma_table_fade_ramp.sv
// Top level of the gamma fade ramp: sequencer, output register, config register.
// Depends on gtfr_pkg, gtfr_step_unit and gtfr_level_store.
//
//  channel | direction | fields (low bit up)
//  in_     | slave     | tdata: channel[2:0], target_level[14:3], pad
//  out_    | master    | tdata: out_channel[2:0], level[10:3], pad;
//          |           | tlast: last; tuser: rejected
//  cfg_    | write     | wr_data: channel_count
//
// One command at a time: accept, load, then a table search through the shared
// compare unit, then one ramp step per cycle (up to TABLE_STEPS steps). A rejected
// channel instead gives one output beat with tuser and tlast set and level zero.
// Output stalls hold the ramp; in_tready is high only while the sequencer idles.
// rst_n is synchronous: stored levels clear to zero and channel_count to 8.
module gamma_table_fade_ramp import gtfr_pkg::*; #(
  parameter int TABLE_STEPS  = 32,
  parameter int MAX_CHANNELS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // command stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // channel[2:0], target_level[14:3]
  // ramp step stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // out_channel[2:0], level[10:3]
  output logic                  out_tlast,  // last
  output logic [0:0]            out_tuser,  // rejected
  // channel_count register
  input  logic                  cfg_wr_en,
  input  logic [CNT_W-1:0]      cfg_wr_data
);

  localparam int IDX_W = $clog2(TABLE_STEPS);
  localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(TABLE_STEPS - 1);
  localparam int LVL_DEPTH = (MAX_CHANNELS < CH_SLOTS) ? MAX_CHANNELS : CH_SLOTS;
  localparam int LVL_AW    = (LVL_DEPTH > 1) ? $clog2(LVL_DEPTH) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_REJ  = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_SRCH = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CH_W-1:0]  ch_r, ch_nxt;
  level_t           tgt_r, tgt_nxt;
  logic             up_r, up_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [CH_W-1:0]  out_ch_r, out_ch_nxt;
  level_t           out_level_r, out_level_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_rej_r, out_rej_nxt;

  logic [CH_W-1:0]  in_ch;
  logic [TGT_W-1:0] in_tgt;
  logic             in_xfer, slot_free, ch_bad;
  level_t           cur_level, operand;
  step_res_t        step;
  lvl_wr_t          lvl_wr;
  logic             at_end;

  assign in_ch  = in_tdata[CH_W-1:0];
  assign in_tgt = in_tdata[CH_W +: TGT_W];

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign ch_bad    = ({1'b0, in_ch} >= count_r) || (32'(in_ch) >= MAX_CHANNELS);

  // search compares against the stored level, ramp steps against the target
  assign operand = (state_r == ST_SRCH) ? cur_level : tgt_r;

  gtfr_step_unit #(.IDX_W(IDX_W)) u_step (
    .idx     (idx_r),
    .operand (operand),
    .res     (step)
  );

  gtfr_level_store #(.DEPTH(LVL_DEPTH), .AW(LVL_AW)) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (lvl_wr),
    .rd_ch    (ch_r),
    .rd_level (cur_level)
  );

  // final step: upward ends at first entry above target or the top entry,
  // downward at the first entry not above target or index zero
  assign at_end = up_r ? (step.gt || (idx_r == IDX_TOP))
                       : (!step.gt || (idx_r == '0));

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    tgt_nxt       = tgt_r;
    up_nxt        = up_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_ch_nxt    = out_ch_r;
    out_level_nxt = out_level_r;
    out_last_nxt  = out_last_r;
    out_rej_nxt   = out_rej_r;
    lvl_wr.en     = 1'b0;
    lvl_wr.ch     = ch_r;
    lvl_wr.level  = step.entry;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          ch_nxt    = in_ch;
          tgt_nxt   = (in_tgt > TGT_W'(LEVEL_MAX)) ? LEVEL_MAX : in_tgt[LVL_W-1:0];
          state_nxt = ch_bad ? ST_REJ : ST_LOAD;
        end
      end
      ST_REJ: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_ch_nxt    = ch_r;
          out_level_nxt = '0;
          out_last_nxt  = 1'b1;
          out_rej_nxt   = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_LOAD: begin
        up_nxt    = (tgt_r > cur_level);
        idx_nxt   = (tgt_r > cur_level) ? '0 : IDX_TOP;
        state_nxt = ST_SRCH;
      end
      ST_SRCH: begin
        // find the start entry relative to the stored level
        if (up_r) begin
          if (step.gt || (idx_r == IDX_TOP)) state_nxt = ST_EMIT;
          else                                idx_nxt   = idx_r + 1'b1;
        end else begin
          if (!step.gt || (idx_r == '0)) state_nxt = ST_EMIT;
          else                            idx_nxt   = idx_r - 1'b1;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_ch_nxt    = ch_r;
          out_level_nxt = step.entry;
          out_last_nxt  = at_end;
          out_rej_nxt   = 1'b0;
          if (at_end) begin
            lvl_wr.en = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = up_r ? (idx_r + 1'b1) : (idx_r - 1'b1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= CNT_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) count_r <= cfg_wr_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ch_r        <= ch_nxt;
    tgt_r       <= tgt_nxt;
    up_r        <= up_nxt;
    idx_r       <= idx_nxt;
    out_ch_r    <= out_ch_nxt;
    out_level_r <= out_level_nxt;
    out_last_r  <= out_last_nxt;
    out_rej_r   <= out_rej_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - CH_W - LVL_W){1'b0}}, out_level_r, out_ch_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_rej_r;

endmodule
